### rtl/core/tls_pkg.sv
// ----------------------------------------------------------------------------
// tls_pkg
// Shared constants and register indexes of the triangle layer slicer.
// ----------------------------------------------------------------------------
package tls_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int LAYER_BITS_DEF  = 16;
    localparam int STEP_W          = 31;
    localparam int TOL_W           = 16;
    localparam int IDX_W           = 2;

    localparam logic [STEP_W-1:0] STEP_RST = 31'd65536;
    localparam logic [TOL_W-1:0]  TOL_RST  = 16'd66;

    typedef logic [IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_BASE = 2'd0;
    localparam t_cfg_idx CFG_STEP = 2'd1;
    localparam t_cfg_idx CFG_TOL  = 2'd2;

endpackage

### rtl/core/tls_divider.sv
// ----------------------------------------------------------------------------
// tls_divider
// Unsigned restoring divider, one quotient bit per stage, CW stages.
// ----------------------------------------------------------------------------
module tls_divider
    import tls_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [2*CW+1:0]   i_num,
    input  logic [CW:0]       i_den,
    output logic [CW-1:0]     o_quo
);

    localparam int DW = CW + 1;

    logic [DW-1:0] r_rem [CW];
    logic [CW-1:0] r_low [CW];
    logic [CW-1:0] r_quo [CW];
    logic [DW-1:0] r_den [CW];

    genvar k;
    generate
        for (k = 0; k < CW; k++) begin : g_stage
            logic [DW-1:0] rem_in;
            logic [CW-1:0] low_in;
            logic [CW-1:0] quo_in;
            logic [DW-1:0] den_in;
            logic [DW:0]   trial;
            logic          ge;
            if (k == 0) begin : g_first
                assign rem_in = i_num[CW+DW-1:CW];
                assign low_in = i_num[CW-1:0];
                assign quo_in = '0;
                assign den_in = i_den;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign low_in = r_low[k-1];
                assign quo_in = r_quo[k-1];
                assign den_in = r_den[k-1];
            end
            assign trial = {rem_in, low_in[CW-1]};
            assign ge    = trial >= {1'b0, den_in};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
                    r_low[k] <= {low_in[CW-2:0], 1'b0};
                    r_quo[k] <= {quo_in[CW-2:0], ge};
                    r_den[k] <= den_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[CW-1];

endmodule

### rtl/core/tls_edge.sv
// ----------------------------------------------------------------------------
// tls_edge
// Crossing of one triangle edge with the slicing plane.
// ----------------------------------------------------------------------------
module tls_edge
    import tls_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_xa,
    input  logic signed [CW-1:0] i_ya,
    input  logic signed [CW-1:0] i_za,
    input  logic signed [CW-1:0] i_xb,
    input  logic signed [CW-1:0] i_yb,
    input  logic signed [CW-1:0] i_zb,
    input  logic signed [CW-1:0] i_h,
    output logic                 o_hit,
    output logic [CW-1:0]        o_x,
    output logic [CW-1:0]        o_z
);

    localparam int DW  = CW + 1;
    localparam int PRW = 2 * DW;
    localparam int SW  = 3 + 2 * CW;

    // stage C: differences
    logic signed [DW-1:0] r_c_dx, r_c_dz, r_c_t, r_c_d;
    logic                 r_c_hit;
    logic [CW-1:0]        r_c_xb, r_c_zb;
    // stage D: magnitudes
    logic [DW-1:0]        r_d_mx, r_d_mz, r_d_mt, r_d_md;
    logic                 r_d_hit, r_d_negx, r_d_negz;
    logic [CW-1:0]        r_d_xb, r_d_zb;
    // stage E: products
    logic [PRW-1:0]       r_e_px, r_e_pz;
    logic [DW-1:0]        r_e_md;
    logic [SW-1:0]        r_e_sb;
    // side band through divider
    logic [SW-1:0]        r_s_sb [CW];

    logic [CW-1:0]        qx, qz;
    logic                 s_hit, s_negx, s_negz;
    logic [CW-1:0]        s_xb, s_zb;
    logic [DW-1:0]        n_x, n_z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_dx  <= {i_xa[CW-1], i_xa} - {i_xb[CW-1], i_xb};
            r_c_dz  <= {i_za[CW-1], i_za} - {i_zb[CW-1], i_zb};
            r_c_t   <= {i_h[CW-1], i_h} - {i_yb[CW-1], i_yb};
            r_c_d   <= {i_ya[CW-1], i_ya} - {i_yb[CW-1], i_yb};
            r_c_hit <= !((i_ya > i_h && i_yb > i_h) || (i_ya < i_h && i_yb < i_h))
                       && (i_ya != i_yb);
            r_c_xb  <= i_xb;
            r_c_zb  <= i_zb;

            r_d_mx   <= r_c_dx[DW-1] ? (~r_c_dx + DW'(1)) : r_c_dx;
            r_d_mz   <= r_c_dz[DW-1] ? (~r_c_dz + DW'(1)) : r_c_dz;
            r_d_mt   <= r_c_t[DW-1] ? (~r_c_t + DW'(1)) : r_c_t;
            r_d_md   <= (r_c_d == '0) ? DW'(1) :
                        (r_c_d[DW-1] ? (~r_c_d + DW'(1)) : r_c_d);
            r_d_negx <= r_c_dx[DW-1] ^ r_c_t[DW-1] ^ r_c_d[DW-1];
            r_d_negz <= r_c_dz[DW-1] ^ r_c_t[DW-1] ^ r_c_d[DW-1];
            r_d_hit  <= r_c_hit;
            r_d_xb   <= r_c_xb;
            r_d_zb   <= r_c_zb;

            r_e_px <= PRW'(r_d_mx) * PRW'(r_d_mt);
            r_e_pz <= PRW'(r_d_mz) * PRW'(r_d_mt);
            r_e_md <= r_d_md;
            r_e_sb <= {r_d_hit, r_d_negx, r_d_negz, r_d_xb, r_d_zb};

            r_s_sb[0] <= r_e_sb;
            for (int i = 1; i < CW; i++) begin
                r_s_sb[i] <= r_s_sb[i-1];
            end
        end
    end

    tls_divider #(.CW(CW)) u_div_x (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_e_px),
        .i_den (r_e_md),
        .o_quo (qx)
    );

    tls_divider #(.CW(CW)) u_div_z (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_e_pz),
        .i_den (r_e_md),
        .o_quo (qz)
    );

    assign {s_hit, s_negx, s_negz, s_xb, s_zb} = r_s_sb[CW-1];

    assign n_x = s_negx ? ({s_xb[CW-1], s_xb} - {1'b0, qx}) : ({s_xb[CW-1], s_xb} + {1'b0, qx});
    assign n_z = s_negz ? ({s_zb[CW-1], s_zb} - {1'b0, qz}) : ({s_zb[CW-1], s_zb} + {1'b0, qz});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit <= s_hit;
            o_x   <= n_x[CW-1:0];
            o_z   <= n_z[CW-1:0];
        end
    end

endmodule

### rtl/core/triangle_layer_slicer_core.sv
// Registered path: stage a, b and c registers, the d delay line beside the edge units, then the output register.
// Throughput: one triangle per cycle; the depth is set by the bit-per-stage
// edge dividers. A stalled output freezes the whole pipeline.
// Reset: synchronous, active low; clears the valid bits and returns the
// registers to base 0, step 1.0, tolerance 66.
// ----------------------------------------------------------------------------
// triangle_layer_slicer_core
// Cuts one triangle with the horizontal plane of a layer, emits a segment,
// the whole triangle, or nothing when the plane misses it.
// ----------------------------------------------------------------------------
module triangle_layer_slicer_core
    import tls_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int LAYER_BITS  = LAYER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  t_cfg_idx             i_cfg_idx,
    input  logic [((COORD_WIDTH > STEP_W) ? COORD_WIDTH : STEP_W)-1:0] i_cfg_data,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // layer_number, first_x/y/z, second_x/y/z, third_x/y/z, zero pad
    input  logic [((LAYER_BITS + 9 * COORD_WIDTH + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // out_layer, plane_height, point_a_x/z, point_b_x/z, point_c_x/z, zero pad
    output logic [((LAYER_BITS + 7 * COORD_WIDTH + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    // piece_kind
    output logic                 o_m_axis_tuser
);

    localparam int CW  = COORD_WIDTH;
    localparam int LB  = LAYER_BITS;
    localparam int PW  = STEP_W + LB;
    localparam int HW  = ((PW > CW) ? PW : CW) + 2;
    localparam int DL  = CW + 3;
    localparam int OBW = LB + 7 * CW;
    localparam int OW  = ((LB + 7 * CW + 7) / 8) * 8;

    logic                 adv;

    logic signed [CW-1:0] r_base;
    logic [STEP_W-1:0]    r_step;
    logic [TOL_W-1:0]     r_tol;

    logic                 r_a_v, r_b_v, r_c_v;
    logic [LB-1:0]        r_a_layer, r_b_layer, r_c_layer;
    logic [PW-1:0]        r_a_prod;
    logic signed [CW-1:0] r_a_x [3], r_a_y [3], r_a_z [3];
    logic signed [CW-1:0] r_b_x [3], r_b_y [3], r_b_z [3];
    logic signed [CW-1:0] r_b_h, r_c_h;
    logic [CW-1:0]        r_c_x [3], r_c_z [3];
    logic                 r_c_none;
    logic [2:0]           r_c_on;

    logic                 r_d_v    [DL];
    logic                 r_d_none [DL];
    logic [2:0]           r_d_on   [DL];
    logic [LB-1:0]        r_d_layer[DL];
    logic [CW-1:0]        r_d_h    [DL];
    logic [CW-1:0]        r_d_x    [DL][3];
    logic [CW-1:0]        r_d_z    [DL][3];

    logic                 r_out_v, r_out_kind;
    logic [LB-1:0]        r_out_layer;
    logic [CW-1:0]        r_out_h, r_out_ax, r_out_az, r_out_bx, r_out_bz, r_out_cx, r_out_cz;

    logic signed [HW-1:0] n_sum, hmax, hmin;
    logic [2:0]           n_above, n_below, n_on;
    logic [2:0]           e_hit;
    logic [CW-1:0]        e_x [3], e_z [3];
    logic                 n_emit, n_kind;
    logic [CW-1:0]        n_ax, n_az, n_bx, n_bz, n_cx, n_cz;

    assign adv             = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = adv;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_step <= STEP_RST;
            r_tol  <= TOL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE: r_base <= i_cfg_data[CW-1:0];
                CFG_STEP: r_step <= i_cfg_data[STEP_W-1:0];
                CFG_TOL:  r_tol  <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_out_v <= 1'b0;
            for (int i = 0; i < DL; i++) begin
                r_d_v[i] <= 1'b0;
            end
        end else if (adv) begin
            r_a_v    <= i_s_axis_tvalid;
            r_b_v    <= r_a_v;
            r_c_v    <= r_b_v;
            r_d_v[0] <= r_c_v;
            for (int i = 1; i < DL; i++) begin
                r_d_v[i] <= r_d_v[i-1];
            end
            r_out_v  <= r_d_v[DL-1] && n_emit;
        end
    end

    // plane height
    assign n_sum = {{(HW-CW){r_base[CW-1]}}, r_base} + {{(HW-PW){1'b0}}, r_a_prod};
    assign hmax  = {{(HW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    assign hmin  = {{(HW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    // vertex classification
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_above[k] = r_b_y[k] > r_b_h;
            n_below[k] = r_b_y[k] < r_b_h;
            n_on[k]    = n_above[k] ?
                         (({r_b_y[k][CW-1], r_b_y[k]} - {r_b_h[CW-1], r_b_h})
                             < {{(CW+1-TOL_W){1'b0}}, r_tol}) :
                         (({r_b_h[CW-1], r_b_h} - {r_b_y[k][CW-1], r_b_y[k]})
                             < {{(CW+1-TOL_W){1'b0}}, r_tol});
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_layer <= i_s_axis_tdata[LB-1:0];
            r_a_prod  <= PW'(r_step) * PW'(i_s_axis_tdata[LB-1:0]);
            for (int k = 0; k < 3; k++) begin
                r_a_x[k] <= i_s_axis_tdata[LB + (3*k)   * CW +: CW];
                r_a_y[k] <= i_s_axis_tdata[LB + (3*k+1) * CW +: CW];
                r_a_z[k] <= i_s_axis_tdata[LB + (3*k+2) * CW +: CW];
            end

            r_b_layer <= r_a_layer;
            r_b_h     <= (n_sum > hmax) ? hmax[CW-1:0] :
                         ((n_sum < hmin) ? hmin[CW-1:0] : n_sum[CW-1:0]);
            r_b_x     <= r_a_x;
            r_b_y     <= r_a_y;
            r_b_z     <= r_a_z;

            r_c_layer <= r_b_layer;
            r_c_h     <= r_b_h;
            r_c_none  <= (n_above == 3'b111) || (n_below == 3'b111);
            r_c_on    <= n_on;
            for (int k = 0; k < 3; k++) begin
                r_c_x[k] <= r_b_x[k];
                r_c_z[k] <= r_b_z[k];
            end

            r_d_none[0]  <= r_c_none;
            r_d_on[0]    <= r_c_on;
            r_d_layer[0] <= r_c_layer;
            r_d_h[0]     <= r_c_h;
            r_d_x[0]     <= r_c_x;
            r_d_z[0]     <= r_c_z;
            for (int i = 1; i < DL; i++) begin
                r_d_none[i]  <= r_d_none[i-1];
                r_d_on[i]    <= r_d_on[i-1];
                r_d_layer[i] <= r_d_layer[i-1];
                r_d_h[i]     <= r_d_h[i-1];
                r_d_x[i]     <= r_d_x[i-1];
                r_d_z[i]     <= r_d_z[i-1];
            end
        end
    end

    // edges v1v2, v1v3, v2v3; the second vertex is the interpolation base
    tls_edge #(.CW(CW)) u_edge_01 (
        .i_clk (i_clk), .i_en (adv),
        .i_xa (r_b_x[0]), .i_ya (r_b_y[0]), .i_za (r_b_z[0]),
        .i_xb (r_b_x[1]), .i_yb (r_b_y[1]), .i_zb (r_b_z[1]),
        .i_h (r_b_h), .o_hit (e_hit[0]), .o_x (e_x[0]), .o_z (e_z[0])
    );

    tls_edge #(.CW(CW)) u_edge_02 (
        .i_clk (i_clk), .i_en (adv),
        .i_xa (r_b_x[0]), .i_ya (r_b_y[0]), .i_za (r_b_z[0]),
        .i_xb (r_b_x[2]), .i_yb (r_b_y[2]), .i_zb (r_b_z[2]),
        .i_h (r_b_h), .o_hit (e_hit[1]), .o_x (e_x[1]), .o_z (e_z[1])
    );

    tls_edge #(.CW(CW)) u_edge_12 (
        .i_clk (i_clk), .i_en (adv),
        .i_xa (r_b_x[1]), .i_ya (r_b_y[1]), .i_za (r_b_z[1]),
        .i_xb (r_b_x[2]), .i_yb (r_b_y[2]), .i_zb (r_b_z[2]),
        .i_h (r_b_h), .o_hit (e_hit[2]), .o_x (e_x[2]), .o_z (e_z[2])
    );

    // piece selection
    always_comb begin
        n_emit = 1'b0;
        n_kind = 1'b0;
        n_ax   = '0;
        n_az   = '0;
        n_bx   = '0;
        n_bz   = '0;
        n_cx   = '0;
        n_cz   = '0;
        case (r_d_on[DL-1])
            3'b000: begin
                n_emit = (e_hit == 3'b011) || (e_hit == 3'b101) || (e_hit == 3'b110);
                n_ax   = e_hit[0] ? e_x[0] : e_x[1];
                n_az   = e_hit[0] ? e_z[0] : e_z[1];
                n_bx   = (e_hit[0] && e_hit[1]) ? e_x[1] : e_x[2];
                n_bz   = (e_hit[0] && e_hit[1]) ? e_z[1] : e_z[2];
            end
            3'b001: begin
                n_emit = e_hit[2];
                n_ax   = r_d_x[DL-1][0];
                n_az   = r_d_z[DL-1][0];
                n_bx   = e_x[2];
                n_bz   = e_z[2];
            end
            3'b010: begin
                n_emit = e_hit[1];
                n_ax   = r_d_x[DL-1][1];
                n_az   = r_d_z[DL-1][1];
                n_bx   = e_x[1];
                n_bz   = e_z[1];
            end
            3'b100: begin
                n_emit = e_hit[0];
                n_ax   = r_d_x[DL-1][2];
                n_az   = r_d_z[DL-1][2];
                n_bx   = e_x[0];
                n_bz   = e_z[0];
            end
            3'b011: begin
                n_emit = 1'b1;
                n_ax   = r_d_x[DL-1][0];
                n_az   = r_d_z[DL-1][0];
                n_bx   = r_d_x[DL-1][1];
                n_bz   = r_d_z[DL-1][1];
            end
            3'b101: begin
                n_emit = 1'b1;
                n_ax   = r_d_x[DL-1][0];
                n_az   = r_d_z[DL-1][0];
                n_bx   = r_d_x[DL-1][2];
                n_bz   = r_d_z[DL-1][2];
            end
            3'b110: begin
                n_emit = 1'b1;
                n_ax   = r_d_x[DL-1][1];
                n_az   = r_d_z[DL-1][1];
                n_bx   = r_d_x[DL-1][2];
                n_bz   = r_d_z[DL-1][2];
            end
            3'b111: begin
                n_emit = 1'b1;
                n_kind = 1'b1;
                n_ax   = r_d_x[DL-1][0];
                n_az   = r_d_z[DL-1][0];
                n_bx   = r_d_x[DL-1][1];
                n_bz   = r_d_z[DL-1][1];
                n_cx   = r_d_x[DL-1][2];
                n_cz   = r_d_z[DL-1][2];
            end
            default: ;
        endcase
        if (r_d_none[DL-1]) begin
            n_emit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_kind  <= n_kind;
            r_out_layer <= r_d_layer[DL-1];
            r_out_h     <= r_d_h[DL-1];
            r_out_ax    <= n_ax;
            r_out_az    <= n_az;
            r_out_bx    <= n_bx;
            r_out_bz    <= n_bz;
            r_out_cx    <= n_cx;
            r_out_cz    <= n_cz;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tdata  = OW'({r_out_cz, r_out_cx, r_out_bz, r_out_bx,
                                 r_out_az, r_out_ax, r_out_h, r_out_layer});

    // checks
    a_seg_no_third: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !r_out_kind |-> (r_out_cx == '0) && (r_out_cz == '0))
        else $error("segment carries a third point");

    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(r_d_v[DL-1]))
        else $error("output beat without pipeline item");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_d_v[DL-1]) && $stable(r_c_v))
        else $error("pipeline moved during stall");

    a_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (OW >= OBW))
        else $error("output packing too narrow");

endmodule

### verif/triangle_layer_slicer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_layer_slicer_core_test
// Streams triangle/layer beats through the slicer under random stalls, predicts
// each segment or whole-triangle piece in the bench and compares every field.
// ----------------------------------------------------------------------------
module triangle_layer_slicer_core_test
    import tls_pkg::*;
();

    localparam int CW    = 32;
    localparam int LB    = 16;
    localparam int IN_W  = ((LB + 9 * CW + 7) / 8) * 8;
    localparam int OUT_W = ((LB + 7 * CW + 7) / 8) * 8;
    localparam int CFG_W = 32;

    localparam t_cfg_idx CFG_IDX_UNUSED_OK = t_cfg_idx'(3);

    typedef struct packed {
        logic            kind;
        logic [LB-1:0]   layer;
        logic [CW-1:0]   height;
        logic [CW-1:0]   ax, az, bx, bz, cx, cz;
    } t_piece;

    typedef struct {
        logic [LB-1:0]        layer;
        logic signed [CW-1:0] x[3], y[3], z[3];
    } t_tri;

    class piece_board;
        longint signed base_q;
        longint unsigned step_q, tol_q;
        t_piece pending[$];
        int     errors;

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_BASE: base_q = longint'(signed'(val));
                CFG_STEP: step_q = 64'(val[30:0]);
                CFG_TOL:  tol_q  = 64'(val[15:0]);
                default: ;
            endcase
        endfunction

        // base + num*t/d truncated toward zero; |num*t| fits 66 bits
        function longint signed lerp(longint signed b, longint signed num,
                                     longint signed t, longint signed d);
            logic signed [127:0] p;
            p = 128'(signed'(num)) * 128'(signed'(t));
            p = p / 128'(signed'(d));
            return b + longint'(p);
        endfunction

        function bit edge_cut(t_tri t, int a, int b, longint signed h,
                              output longint signed px, output longint signed pz);
            longint signed ya, yb;
            ya = t.y[a]; yb = t.y[b];
            px = 0; pz = 0;
            if ((ya > h && yb > h) || (ya < h && yb < h) || ya == yb) return 0;
            px = lerp(t.x[b], longint'(t.x[a]) - t.x[b], h - yb, ya - yb);
            pz = lerp(t.z[b], longint'(t.z[a]) - t.z[b], h - yb, ya - yb);
            return 1;
        endfunction

        function void note_triangle(t_tri t);
            longint signed h, d, px[3], pz[3], x, zz;
            int on, npts, idx[3];
            int ea[3], eb[3];
            t_piece r;
            ea = '{0, 0, 1}; eb = '{1, 2, 2};
            on = 0; npts = 0;
            px = '{0, 0, 0}; pz = '{0, 0, 0};
            h = base_q + longint'(step_q * t.layer);
            if (h > 64'sd2147483647) h = 64'sd2147483647;
            if (h < -64'sd2147483648) h = -64'sd2147483648;
            if ((t.y[0] > h && t.y[1] > h && t.y[2] > h) ||
                (t.y[0] < h && t.y[1] < h && t.y[2] < h)) return;
            for (int i = 0; i < 3; i++) begin
                d = t.y[i] - h;
                if (d < 0) d = -d;
                if (longint'(d) < longint'(tol_q)) begin
                    idx[on] = i;
                    on++;
                end
            end
            if (on == 0) begin
                for (int i = 0; i < 3; i++)
                    if (edge_cut(t, ea[i], eb[i], h, x, zz)) begin
                        if (npts < 3) begin px[npts] = x; pz[npts] = zz; end
                        npts++;
                    end
            end else if (on == 1) begin
                px[0] = t.x[idx[0]]; pz[0] = t.z[idx[0]]; npts = 1;
                if (edge_cut(t, idx[0] == 0 ? 1 : 0, idx[0] == 2 ? 1 : 2, h, x, zz)) begin
                    px[1] = x; pz[1] = zz; npts = 2;
                end
            end else begin
                for (int i = 0; i < on; i++) begin
                    px[i] = t.x[idx[i]]; pz[i] = t.z[idx[i]];
                end
                npts = on;
            end
            if (on != 3 && npts != 2) return;
            if (on != 3) begin px[2] = 0; pz[2] = 0; end
            r.kind = (on == 3); r.layer = t.layer; r.height = h[CW-1:0];
            r.ax = px[0][CW-1:0]; r.az = pz[0][CW-1:0];
            r.bx = px[1][CW-1:0]; r.bz = pz[1][CW-1:0];
            r.cx = px[2][CW-1:0]; r.cz = pz[2][CW-1:0];
            pending = {pending, r};
        endfunction

        function void check_piece(t_piece got);
            t_piece exp;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected piece %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10)
                    $display("piece mismatch: exp %h got %h", exp, got);
            end
        endfunction
    endclass

    logic             i_clk = 0, i_rst_n = 0;
    logic             i_cfg_we = 0;
    t_cfg_idx         i_cfg_idx = CFG_BASE;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_s_axis_tvalid = 0, i_m_axis_tready = 0;
    logic [IN_W-1:0]  i_s_axis_tdata = '0;
    logic             o_s_axis_tready, o_m_axis_tvalid, o_m_axis_tuser;
    logic [OUT_W-1:0] o_m_axis_tdata;

    piece_board board;
    bit         calm = 0;

    triangle_layer_slicer_core u_dut (.*);

    initial forever #6 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // output side: random stalls, sample at rising edge
    initial begin
        t_piece got;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
            i_m_axis_tready <= 1;
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                got.kind   = o_m_axis_tuser;
                got.layer  = o_m_axis_tdata[LB-1:0];
                got.height = o_m_axis_tdata[LB +: CW];
                got.ax = o_m_axis_tdata[LB + CW +: CW];
                got.az = o_m_axis_tdata[LB + 2*CW +: CW];
                got.bx = o_m_axis_tdata[LB + 3*CW +: CW];
                got.bz = o_m_axis_tdata[LB + 4*CW +: CW];
                got.cx = o_m_axis_tdata[LB + 5*CW +: CW];
                got.cz = o_m_axis_tdata[LB + 6*CW +: CW];
                board.check_piece(got);
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.set_reg(idx, val);
    endtask

    task automatic send_tri(t_tri t);
        logic [IN_W-1:0] d;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        d = '0;
        d[LB-1:0] = t.layer;
        for (int i = 0; i < 3; i++) begin
            d[LB + (3*i)*CW +: CW]   = t.x[i];
            d[LB + (3*i+1)*CW +: CW] = t.y[i];
            d[LB + (3*i+2)*CW +: CW] = t.z[i];
        end
        i_s_axis_tdata <= d;
        i_s_axis_tvalid <= 1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_triangle(t);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    function automatic logic [CW-1:0] rnd32();
        return $urandom;
    endfunction

    // random triangle, mode picks the shape: mode 0 spreads y over the full range, other modes mostly near the plane
    function automatic t_tri make_tri(int mode);
        t_tri t;
        longint signed h, s;
        t.layer = (mode == 0) ? LB'($urandom) : LB'($urandom_range(0, 40));
        h = board.base_q + longint'(board.step_q * t.layer);
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        if (h < -64'sd2147483648) h = -64'sd2147483648;
        for (int i = 0; i < 3; i++) begin
            t.x[i] = rnd32(); t.z[i] = rnd32();
            case (mode == 0 ? 0 : $urandom_range(0, 4))
                0: t.y[i] = rnd32();
                1: t.y[i] = CW'(h);
                2: t.y[i] = CW'(h + $signed($urandom_range(0, 200)) - 100);
                default: begin
                    s = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
                    s = h + s;
                    if (s > 64'sd2147483647) s = 64'sd2147483647;
                    if (s < -64'sd2147483648) s = -64'sd2147483648;
                    t.y[i] = CW'(s);
                end
            endcase
        end
        return t;
    endfunction

    function automatic t_tri flat_tri(logic [LB-1:0] l, logic signed [CW-1:0] y0,
                                      logic signed [CW-1:0] y1, logic signed [CW-1:0] y2,
                                      logic signed [CW-1:0] v);
        t_tri t;
        t.layer = l;
        t.y[0] = y0; t.y[1] = y1; t.y[2] = y2;
        for (int i = 0; i < 3; i++) begin t.x[i] = v ^ CW'(i); t.z[i] = ~v + CW'(i); end
        return t;
    endfunction

    initial begin
        logic signed [CW-1:0] mx, mn;
        board = new();
        board.set_reg(CFG_BASE, 0);
        board.set_reg(CFG_STEP, 65536);
        board.set_reg(CFG_TOL, 66);
        mx = 32'sh7fffffff; mn = 32'sh80000000;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: reset settings, plane at layer*1.0
        send_tri(flat_tri(16'd2, 32'sh30000, 32'sh10000, 32'sh40000, 32'sh1234));  // two crossings
        send_tri(flat_tri(16'd9, 32'sh30000, 32'sh10000, 32'sh40000, 32'sh1234));  // all below
        send_tri(flat_tri(16'd2, 32'sh30000, 32'sh10000, 32'sh28000, 32'sh5555));  // two crossings
        send_tri(flat_tri(16'd2, 32'sh20010, 32'sh10000, 32'sh30000, 32'sh777));   // one on, cut
        send_tri(flat_tri(16'd2, 32'sh20000, 32'sh30000, 32'sh30000, 32'sh777));   // one on, none
        send_tri(flat_tri(16'd2, 32'sh20000, 32'sh20020, 32'sh30000, 32'sh999));   // two on
        send_tri(flat_tri(16'd2, 32'sh20000, 32'sh1ffd0, 32'sh20041, 32'sh999));   // whole
        send_tri(flat_tri(16'd2, 32'sh20042, 32'sh20000, 32'sh10000, 32'sh999));   // tol edge
        send_tri(flat_tri(16'd2, 32'sh30000, 32'sh10000, 32'sh30000, mx));         // level edge
        send_tri(flat_tri(16'd0, mx, mn, 32'sh0, mn));                             // extremes
        send_tri(flat_tri(16'hffff, mx, mx, mn, mx));                              // sat high
        drain();

        write_reg(CFG_TOL, 0);
        send_tri(flat_tri(16'd1, 32'sh10000, 32'sh10000, 32'sh0, 32'sh42));       // exact, tol 0
        send_tri(flat_tri(16'd1, 32'sh10000, 32'sh20000, 32'sh0, 32'sh42));
        send_tri(flat_tri(16'd1, 32'sh10000, 32'sh8000, 32'sh20000, 32'sh42));
        drain();
        write_reg(CFG_BASE, mn);
        write_reg(CFG_STEP, 32'h7fffffff);
        write_reg(CFG_TOL, 32'hffff);
        write_reg(CFG_IDX_UNUSED_OK, 32'hdeadbeef);
        send_tri(flat_tri(16'd0, mn, mn + 5, 32'sh0, mx));                         // plane at low bound
        send_tri(flat_tri(16'hffff, mx, mx - 3, 32'sh0, mn));
        send_tri(flat_tri(16'd1, 32'sh7ffffff, 32'sh0, 32'sh0, 32'sh3));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_BASE, 0); write_reg(CFG_STEP, 65536);
                         write_reg(CFG_TOL, 66); end
                1: begin write_reg(CFG_BASE, rnd32()); write_reg(CFG_STEP, $urandom_range(0, 1 << 20));
                         write_reg(CFG_TOL, $urandom_range(0, 4000)); end
                2: begin write_reg(CFG_BASE, mx); write_reg(CFG_STEP, 0);
                         write_reg(CFG_TOL, 0); end
                3: begin write_reg(CFG_BASE, mn); write_reg(CFG_STEP, 32'h7fffffff);
                         write_reg(CFG_TOL, 32'hffff); end
                4: begin write_reg(CFG_BASE, rnd32()); write_reg(CFG_STEP, $urandom);
                         write_reg(CFG_TOL, $urandom); end
                default: begin calm = 1; write_reg(CFG_BASE, 32'shfff00000);
                         write_reg(CFG_STEP, 32'h18000); write_reg(CFG_TOL, 100); end
            endcase
            for (int n = 0; n < 75; n++)
                send_tri(make_tri($urandom_range(0, 4) == 0 ? 0 : 1));
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
